>>> hw/rtl/mlc_pkg.sv
// Package for the mu-law compander: request/result types, the queue entry type and constants.
package mlc_pkg;

  // Item kinds
  localparam logic KIND_ENCODE = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  // Encoder constants
  localparam logic [15:0] MU_CLIP = 16'd32635;
  localparam logic [14:0] MU_BIAS = 15'h0084;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic               kind;
    logic signed [15:0] linear_sample;
    logic        [7:0]  code_byte;
  } mlc_in_t;

  typedef struct packed {
    logic        [7:0]  code_out;
    logic signed [15:0] linear_out;
  } mlc_out_t;

  // Classified request: for encode, mag is the clipped and biased magnitude;
  // for decode, sgn and mag[6:0] hold the inverted byte.
  typedef struct packed {
    logic        kind;
    logic        sgn;
    logic [14:0] mag;
  } mlc_cmd_t;

  // Segment base for decoding: 132 * 2^e - 132
  function automatic logic [14:0] seg_base(input logic [2:0] e);
    logic [14:0] base;
    begin
      case (e)
        3'd0:    base = 15'd0;
        3'd1:    base = 15'd132;
        3'd2:    base = 15'd396;
        3'd3:    base = 15'd924;
        3'd4:    base = 15'd1980;
        3'd5:    base = 15'd4092;
        3'd6:    base = 15'd8316;
        3'd7:    base = 15'd16764;
        default: base = 15'd0;
      endcase
      return base;
    end
  endfunction

endpackage

>>> hw/rtl/mlc_front.sv
// Front part: accepts requests and classifies them into queue entries.
module mlc_front (
  input  logic              start,
  input  logic              q_full,
  input  mlc_pkg::mlc_in_t  in_req,
  output logic              busy,
  output logic              push,
  output mlc_pkg::mlc_cmd_t cmd
);

  logic [15:0] neg_mag;
  logic [15:0] abs_mag;
  logic [15:0] clip_mag;
  logic [7:0]  inv_byte;

  // Hold requests off only when the queue has no room
  assign busy = q_full;
  assign push = start && !q_full;

  // Take sign and magnitude, clip and add the bias
  always_comb begin
    neg_mag  = 16'(16'd0 - in_req.linear_sample);
    abs_mag  = in_req.linear_sample[15] ? neg_mag : {1'b0, in_req.linear_sample[14:0]};
    clip_mag = (abs_mag > mlc_pkg::MU_CLIP) ? mlc_pkg::MU_CLIP : abs_mag;
    inv_byte = ~in_req.code_byte;
  end

  // Build the queue entry for the chosen kind
  always_comb begin
    cmd.kind = in_req.kind;
    if (in_req.kind == mlc_pkg::KIND_ENCODE) begin
      cmd.sgn = in_req.linear_sample[15];
      cmd.mag = 15'(clip_mag) + mlc_pkg::MU_BIAS;
    end else begin
      cmd.sgn = inv_byte[7];
      cmd.mag = {8'd0, inv_byte[6:0]};
    end
  end

endmodule

>>> hw/rtl/mlc_queue.sv
// Short queue between front and back.
module mlc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mlc_pkg::mlc_cmd_t push_cmd,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output mlc_pkg::mlc_cmd_t head
);

  mlc_pkg::mlc_cmd_t entry_r [mlc_pkg::QUEUE_DEPTH];
  logic [mlc_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [mlc_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [mlc_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       do_pop;

  assign full      = (cnt_r == mlc_pkg::QCNT_W'(mlc_pkg::QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = entry_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == mlc_pkg::QPTR_W'(mlc_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == mlc_pkg::QPTR_W'(mlc_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> hw/rtl/mlc_back.sv
// Back part: encodes or decodes the queue head and registers the result.
module mlc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              avail,
  input  mlc_pkg::mlc_cmd_t cmd,
  output logic              pop,
  output logic              out_strobe,
  output mlc_pkg::mlc_out_t out_res
);

  logic [7:0]  top;
  logic [2:0]  enc_e;
  logic [3:0]  enc_shamt;
  logic [14:0] enc_shifted;
  logic [7:0]  enc_code;
  logic [2:0]  dec_e;
  logic [3:0]  dec_shamt;
  logic [15:0] dec_mag;
  logic [15:0] dec_lin;
  logic              strobe_r, strobe_nxt;
  mlc_pkg::mlc_out_t res_r, res_nxt;

  // The receiver never stalls, so drain one entry every cycle while one is queued
  assign pop = avail;

  // Find the segment from the leading one of bits 14..7
  always_comb begin
    top = cmd.mag[14:7];
    casez (top)
      8'b1???????: enc_e = 3'd7;
      8'b01??????: enc_e = 3'd6;
      8'b001?????: enc_e = 3'd5;
      8'b0001????: enc_e = 3'd4;
      8'b00001???: enc_e = 3'd3;
      8'b000001??: enc_e = 3'd2;
      8'b0000001?: enc_e = 3'd1;
      default:     enc_e = 3'd0;
    endcase
    enc_shamt   = {1'b0, enc_e} + 4'd3;
    enc_shifted = cmd.mag >> enc_shamt;
    enc_code    = ~{cmd.sgn, enc_e, enc_shifted[3:0]};
  end

  // Rebuild the magnitude from segment base and mantissa, then apply sign
  always_comb begin
    dec_e     = cmd.mag[6:4];
    dec_shamt = {1'b0, dec_e} + 4'd3;
    dec_mag   = {1'b0, mlc_pkg::seg_base(dec_e)} + (16'(cmd.mag[3:0]) << dec_shamt);
    dec_lin   = cmd.sgn ? 16'(16'd0 - dec_mag) : dec_mag;
  end

  // Select the result fields
  always_comb begin
    strobe_nxt = avail;
    if (cmd.kind == mlc_pkg::KIND_ENCODE) begin
      res_nxt.code_out   = enc_code;
      res_nxt.linear_out = '0;
    end else begin
      res_nxt.code_out   = '0;
      res_nxt.linear_out = dec_lin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_res    = res_r;

endmodule

>>> hw/rtl/mu_law_compander_top.sv
// Top level of the mu-law compander.
//
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   in_req.kind selects encode (linear_sample to an 8-bit mu-law byte) or
//   decode (code_byte to a signed linear sample).
//   Each request yields exactly one result on out_res, marked by out_strobe
//   for one cycle; the unused result field is zero.
// Structure and throughput:
//   The front classifies a request (sign, clip, bias or byte inversion) and
//   writes it into a two-entry queue; the back reads the queue head,
//   finds the segment or rebuilds the magnitude, and registers the result.
//   The request is registered in the queue, then the result in the back's
//   output register. One request per cycle is sustained while busy is low.
// Reset:
//   rst_n is synchronous and active low; it empties the queue and clears the
//   strobe. Results are in request order.
// Stalls:
//   The receiver cannot stall; the back drains the queue every cycle, so
//   busy stays low in normal use.
module mu_law_compander_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mlc_pkg::mlc_in_t  in_req,
  output logic              out_strobe,
  output mlc_pkg::mlc_out_t out_res
);

  logic              q_full;
  logic              q_not_empty;
  logic              push;
  logic              pop;
  mlc_pkg::mlc_cmd_t push_cmd;
  mlc_pkg::mlc_cmd_t head_cmd;

  mlc_front u_front (
    .start  (start),
    .q_full (q_full),
    .in_req (in_req),
    .busy   (busy),
    .push   (push),
    .cmd    (push_cmd)
  );

  mlc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head_cmd)
  );

  mlc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .avail      (q_not_empty),
    .cmd        (head_cmd),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  // Every result comes from an earlier request that was taken
  a_strobe_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 2))
    else $error("result strobe without a matching request");

  // A request taken is answered with a result strobe
  a_request_answered: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_strobe)
    else $error("request was not answered");

  // Only one of the result fields may be nonzero
  a_fields_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.linear_out != 16'sd0) |-> (out_res.code_out == 8'd0))
    else $error("both result fields nonzero");

  // Encoding a zero sample gives 0xFF
  a_zero_encode: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.kind == mlc_pkg::KIND_ENCODE
     && in_req.linear_sample == 16'sd0) |-> ##2 (out_res.code_out == 8'hFF))
    else $error("zero sample encoded wrongly");

endmodule
